FILE: rtl/gsig_pkg.sv
// Shared constants, codes and types of the grid strip index generator.
package gsig_pkg;

   localparam int MAX_ROW_LENGTH = 1024;
   localparam int MAX_STRIPS     = 1024;
   localparam int INDEX_BITS     = 16;

   localparam int LEN_W    = 11;
   localparam int COL_W    = $clog2(MAX_ROW_LENGTH);
   localparam int STRIP_W  = $clog2(MAX_STRIPS);
   localparam int BASE_W   = 21;
   localparam int SUM_W    = BASE_W + 1;
   localparam int CSR_IDX_W = 2;

   localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_ROW_LENGTH);
   localparam logic [LEN_W-1:0] CNT_MIN = LEN_W'(1);
   localparam logic [LEN_W-1:0] CNT_MAX = LEN_W'(MAX_STRIPS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_LENGTH  = 2'd0,
      CSR_STRIP_COUNT = 2'd1,
      CSR_WRAP_ROWS   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_BODY    = 3'b001,
      PH_STITCH1 = 3'b010,
      PH_STITCH2 = 3'b100
   } phase_type;

   typedef struct packed {
      logic [LEN_W-1:0] row_length;
      logic [LEN_W-1:0] strip_count;
      logic             wrap_rows;
   } cfg_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] vertex_index;
      logic                  is_degenerate;
      logic                  last_of_mesh;
      logic                  idle;
      logic                  range_error;
   } result_type;

   typedef struct packed {
      logic busy;
      logic stitching;
   } status_type;

endpackage

FILE: rtl/gsig_ifs.sv
// Handshake channel interfaces: request, response and register write.
interface gsig_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface gsig_rsp_if;
   import gsig_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] vertex_index;
   logic                  is_degenerate;
   logic                  last_of_mesh;
   logic                  idle;
   logic                  range_error;
   modport source (output valid, output vertex_index, output is_degenerate,
                   output last_of_mesh, output idle, output range_error, input ready);
   modport sink   (input valid, input vertex_index, input is_degenerate,
                   input last_of_mesh, input idle, input range_error, output ready);
endinterface

interface gsig_csr_if;
   import gsig_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [LEN_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/gsig_core.sv
// Strip walker: mesh state registers and the combinational index step.
module gsig_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 restart,
   input  gsig_pkg::cfg_type    cfg,
   output gsig_pkg::result_type result,
   output gsig_pkg::status_type status
);
   import gsig_pkg::*;

   logic [STRIP_W-1:0] strip_ff, strip_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic               upper_turn_ff, upper_turn_in;
   phase_type          phase_ff, phase_in;
   logic               busy_ff, busy_in;
   logic [BASE_W-1:0]  lower_base_ff, lower_base_in;
   logic [BASE_W-1:0]  upper_base_ff, upper_base_in;

   logic [LEN_W-1:0]   len_eff, cnt_eff;
   logic [STRIP_W-1:0] s_cur, load_s;
   logic [COL_W-1:0]   c_cur;
   logic               ut_cur, b_cur, load, col_end, strip_end;
   phase_type          ph_cur;
   logic [BASE_W-1:0]  lo_cur;
   logic [LEN_W-1:0]   up_row;
   logic [BASE_W-1:0]  prod_lo, prod_up;
   logic [SUM_W-1:0]   idx;
   logic               err;

   always_comb begin
      if (cfg.row_length < LEN_MIN) begin
         len_eff = LEN_MIN;
      end else if (cfg.row_length > LEN_MAX) begin
         len_eff = LEN_MAX;
      end else begin
         len_eff = cfg.row_length;
      end
      if (cfg.strip_count < CNT_MIN) begin
         cnt_eff = CNT_MIN;
      end else if (cfg.strip_count > CNT_MAX) begin
         cnt_eff = CNT_MAX;
      end else begin
         cnt_eff = cfg.strip_count;
      end
   end

   // a restart word sees a freshly started mesh
   assign s_cur  = restart ? '0 : strip_ff;
   assign c_cur  = restart ? '0 : col_ff;
   assign ut_cur = restart ? 1'b0 : upper_turn_ff;
   assign ph_cur = restart ? PH_BODY : phase_ff;
   assign b_cur  = restart | busy_ff;
   assign lo_cur = restart ? '0 : lower_base_ff;

   assign col_end   = LEN_W'(c_cur) >= (len_eff - LEN_W'(1));
   assign strip_end = LEN_W'(s_cur) >= (cnt_eff - LEN_W'(1));

   // row bases of the strip being entered
   assign load_s = restart ? '0 : STRIP_W'(strip_ff + STRIP_W'(1));
   always_comb begin
      up_row = LEN_W'(load_s) + LEN_W'(1);
      if (cfg.wrap_rows && (up_row >= cnt_eff)) begin
         up_row = '0;
      end
   end
   assign prod_lo = BASE_W'(load_s) * BASE_W'(len_eff);
   assign prod_up = BASE_W'(up_row) * BASE_W'(len_eff);

   always_comb begin
      strip_in      = s_cur;
      col_in        = c_cur;
      upper_turn_in = ut_cur;
      phase_in      = ph_cur;
      busy_in       = b_cur;
      load          = restart;
      idx           = '0;
      err           = 1'b0;
      result        = '0;
      if (!b_cur) begin
         result.idle = 1'b1;
      end else begin
         unique case (ph_cur)
            PH_STITCH1: begin
               idx                  = SUM_W'(upper_base_ff) + SUM_W'(len_eff) - SUM_W'(1);
               result.is_degenerate = 1'b1;
               phase_in             = PH_STITCH2;
            end
            PH_STITCH2: begin
               idx                  = SUM_W'(upper_base_ff);
               result.is_degenerate = 1'b1;
               phase_in             = PH_BODY;
               strip_in             = load_s;
               col_in               = '0;
               upper_turn_in        = 1'b0;
               load                 = 1'b1;
            end
            PH_BODY: begin
               if (ut_cur) begin
                  idx           = SUM_W'(upper_base_ff) + SUM_W'(c_cur);
                  upper_turn_in = 1'b0;
                  if (col_end) begin
                     if (strip_end) begin
                        result.last_of_mesh = 1'b1;
                        busy_in             = 1'b0;
                     end else begin
                        phase_in = PH_STITCH1;
                     end
                     col_in = '0;
                  end else begin
                     col_in = COL_W'(c_cur + COL_W'(1));
                  end
               end else begin
                  idx           = SUM_W'(lo_cur) + SUM_W'(c_cur);
                  upper_turn_in = 1'b1;
               end
            end
            default: begin
               phase_in = PH_BODY;
            end
         endcase
         // saturate above the index capacity
         err                 = (idx >> INDEX_BITS) != '0;
         result.range_error  = err;
         result.vertex_index = err ? '1 : idx[INDEX_BITS-1:0];
      end
      lower_base_in = load ? prod_lo : lo_cur;
      upper_base_in = load ? prod_up : upper_base_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_ff      <= '0;
         col_ff        <= '0;
         upper_turn_ff <= 1'b0;
         phase_ff      <= PH_BODY;
         busy_ff       <= 1'b0;
         lower_base_ff <= '0;
         upper_base_ff <= '0;
      end else if (accept) begin
         strip_ff      <= strip_in;
         col_ff        <= col_in;
         upper_turn_ff <= upper_turn_in;
         phase_ff      <= phase_in;
         busy_ff       <= busy_in;
         lower_base_ff <= lower_base_in;
         upper_base_ff <= upper_base_in;
      end
   end

   assign status.busy      = busy_ff;
   assign status.stitching = (phase_ff != PH_BODY);

endmodule

FILE: rtl/grid_strip_index_generator.sv
// Top level: register file, strip walker and two-entry response buffer.
// A taken request's response is registered in the response register, or in the skid entry
// while that register is held. Requests are taken one word per cycle while the skid entry is
// empty. The whole index step is combinational between the mesh state and response registers.
// A two-entry response buffer keeps requests flowing while one response waits.
// Reset (synchronous, active high) returns registers to their defaults and the walker to idle.
module grid_strip_index_generator (
   input logic       clock,
   input logic       reset,
   gsig_req_if.sink  req_chan,
   gsig_rsp_if.source rsp_chan,
   gsig_csr_if.sink  csr_chan
);
   import gsig_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   result_type out_ff, skid_ff, core_result;
   logic       out_valid_ff, skid_valid_ff;
   status_type core_status;
   logic       accept, pop;

   // register writes
   assign csr_chan.ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_ROW_LENGTH:  cfg_in.row_length  = csr_chan.data;
            CSR_STRIP_COUNT: cfg_in.strip_count = csr_chan.data;
            CSR_WRAP_ROWS:   cfg_in.wrap_rows   = csr_chan.data[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_length  <= LEN_MIN;
         cfg_ff.strip_count <= CNT_MIN;
         cfg_ff.wrap_rows   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_chan.ready = !skid_valid_ff;
   assign accept = req_chan.valid && req_chan.ready;
   assign pop    = out_valid_ff && rsp_chan.ready;

   gsig_core u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .restart (req_chan.restart),
      .cfg     (cfg_ff),
      .result  (core_result),
      .status  (core_status)
   );

   // response register with skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_ff <= core_result;
         end else begin
            skid_ff <= core_result;
         end
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.vertex_index  = out_ff.vertex_index;
   assign rsp_chan.is_degenerate = out_ff.is_degenerate;
   assign rsp_chan.last_of_mesh  = out_ff.last_of_mesh;
   assign rsp_chan.idle          = out_ff.idle;
   assign rsp_chan.range_error   = out_ff.range_error;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty response register");

   a_last_ends_mesh: assert property (@(posedge clock) disable iff (reset)
      (accept && core_result.last_of_mesh) |=> !core_status.busy)
      else $error("mesh still busy after its last word");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.idle) |-> (out_ff.vertex_index == '0 &&
         !out_ff.is_degenerate && !out_ff.last_of_mesh && !out_ff.range_error))
      else $error("idle response carries an index or flag");

   a_stitch_not_last: assert property (@(posedge clock) disable iff (reset)
      (accept && core_status.stitching && !req_chan.restart) |-> !core_result.last_of_mesh)
      else $error("mesh ended during stitching");
`endif

endmodule

FILE: tb/tb_grid_strip_index_generator.sv
// Testbench for the grid strip index generator: directed and random index walks.
`timescale 1ns / 1ps

module tb_grid_strip_index_generator;
   import gsig_pkg::*;

   localparam int unsigned CYCLE_LIMIT      = 200000;
   localparam int unsigned DRAIN_CYCLES     = 8;
   localparam int unsigned HOLD_OFF_CYCLES  = 300;
   localparam int unsigned INDEX_CAP        = (1 << INDEX_BITS) - 1;
   // At 1024 vertices per row, strip 64 starts beyond the 16-bit index range.
   localparam int unsigned SATURATING_STRIP = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   logic clock = 1'b0;
   logic reset;

   gsig_req_if req_chan ();
   gsig_rsp_if rsp_chan ();
   gsig_csr_if csr_chan ();

   grid_strip_index_generator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #5 clock = ~clock;

   // Strip walker state as seen from outside.
   cfg_type                mesh_cfg;
   logic [STRIP_W-1:0]     strip_no;
   logic [COL_W-1:0]       col_no;
   logic                   on_upper;
   phase_type              walk_phase;
   logic                   mesh_active;
   int unsigned            lower_base;
   int unsigned            upper_base;

   result_type             pending_indices[$];
   int unsigned            failures = 0;
   int unsigned            cycle_count = 0;
   int unsigned            send_gap_pct = 0;
   int unsigned            recv_stall_pct = 0;
   int unsigned            hold_off_left = 0;

   function automatic int unsigned clamped_length();
      if (mesh_cfg.row_length < LEN_MIN) return LEN_MIN;
      if (mesh_cfg.row_length > LEN_MAX) return LEN_MAX;
      return mesh_cfg.row_length;
   endfunction

   function automatic int unsigned clamped_count();
      if (mesh_cfg.strip_count < CNT_MIN) return CNT_MIN;
      if (mesh_cfg.strip_count > CNT_MAX) return CNT_MAX;
      return mesh_cfg.strip_count;
   endfunction

   function automatic void load_row_bases(input int unsigned strip);
      int unsigned up;
      up = strip + 1;
      if (mesh_cfg.wrap_rows && up >= clamped_count()) up = 0;
      lower_base = strip * clamped_length();
      upper_base = up * clamped_length();
   endfunction

   function automatic result_type next_index(input logic restart);
      result_type  r;
      int unsigned len;
      int unsigned cnt;
      int unsigned idx;
      logic        col_end;
      logic        strip_end;
      r = '0;
      if (restart) begin
         mesh_active = 1'b1;
         strip_no    = '0;
         col_no      = '0;
         on_upper    = 1'b0;
         walk_phase  = PH_BODY;
         load_row_bases(0);
      end
      if (!mesh_active) begin
         r.idle = 1'b1;
         return r;
      end
      len       = clamped_length();
      cnt       = clamped_count();
      col_end   = col_no >= len - 1;
      strip_end = strip_no >= cnt - 1;
      case (walk_phase)
         PH_STITCH1: begin
            idx             = upper_base + len - 1;
            r.is_degenerate = 1'b1;
            walk_phase      = PH_STITCH2;
         end
         PH_STITCH2: begin
            idx             = upper_base;
            r.is_degenerate = 1'b1;
            walk_phase      = PH_BODY;
            strip_no        = strip_no + 1'b1;
            col_no          = '0;
            on_upper        = 1'b0;
            load_row_bases(strip_no);
         end
         default: begin
            if (on_upper) begin
               idx      = upper_base + col_no;
               on_upper = 1'b0;
               if (col_end) begin
                  if (strip_end) begin
                     r.last_of_mesh = 1'b1;
                     mesh_active    = 1'b0;
                  end else begin
                     walk_phase = PH_STITCH1;
                  end
                  col_no = '0;
               end else begin
                  col_no = col_no + 1'b1;
               end
            end else begin
               idx      = lower_base + col_no;
               on_upper = 1'b1;
            end
         end
      endcase
      if (idx > INDEX_CAP) begin
         idx           = INDEX_CAP;
         r.range_error = 1'b1;
      end
      r.vertex_index = idx[INDEX_BITS-1:0];
      return r;
   endfunction

   function automatic logic [LEN_W-1:0] boundary_value(input int unsigned sel);
      case (sel)
         0: return '0;
         1: return LEN_W'(1);
         2: return LEN_W'(2);
         3: return LEN_MAX;
         4: return LEN_MAX + 1'b1;
         default: return '1;
      endcase
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   // Compare each accepted response word with the oldest prediction.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_indices.size() == 0) begin
            $error("response word with no request outstanding: index %0d",
                   rsp_chan.vertex_index);
            failures++;
         end else begin
            want = pending_indices.pop_front();
            check_field("vertex_index", want.vertex_index, rsp_chan.vertex_index);
            check_field("is_degenerate", want.is_degenerate, rsp_chan.is_degenerate);
            check_field("last_of_mesh", want.last_of_mesh, rsp_chan.last_of_mesh);
            check_field("idle", want.idle, rsp_chan.idle);
            check_field("range_error", want.range_error, rsp_chan.range_error);
         end
      end
   end

   // Receiver: hold off for a counted stretch when asked, else stall at random.
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_off_left--;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Entered and left at a falling edge; valid stays high for a following word.
   task automatic send_word(input logic restart);
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.restart <= restart;
      do @(posedge clock); while (!req_chan.ready);
      pending_indices.push_back(next_index(restart));
      @(negedge clock);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_indices.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [LEN_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      case (index)
         CSR_ROW_LENGTH:  mesh_cfg.row_length  = value;
         CSR_STRIP_COUNT: mesh_cfg.strip_count = value;
         CSR_WRAP_ROWS:   mesh_cfg.wrap_rows   = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic test_reset_defaults();
      send_word(1'b0);
      send_word(1'b1);
      repeat (3) send_word(1'b0);
      send_word(1'b0);
   endtask

   task automatic test_wrapped_ring();
      settle();
      write_reg(CSR_ROW_LENGTH, LEN_W'(3));
      write_reg(CSR_STRIP_COUNT, LEN_W'(2));
      write_reg(CSR_WRAP_ROWS, LEN_W'(1));
      send_word(1'b1);
      repeat (14) send_word(1'b0);
   endtask

   task automatic test_restart_mid_mesh();
      send_word(1'b1);
      repeat (4) send_word(1'b0);
      send_word(1'b1);
      send_word(1'b1);
      repeat (2) send_word(1'b0);
   endtask

   task automatic test_single_strip_wrap();
      settle();
      write_reg(CSR_STRIP_COUNT, LEN_W'(1));
      write_reg(CSR_ROW_LENGTH, LEN_W'(2));
      send_word(1'b1);
      repeat (3) send_word(1'b0);
   endtask

   task automatic test_register_saturation();
      for (int sel = 0; sel < 6; sel++) begin
         settle();
         write_reg(CSR_ROW_LENGTH, boundary_value(sel));
         write_reg(CSR_STRIP_COUNT, boundary_value(5 - sel));
         send_word(1'b1);
         repeat (3) send_word(1'b0);
      end
      // Unmapped index and upper wrap bits must leave the walk unchanged.
      settle();
      write_reg(CSR_SPARE_INDEX, '1);
      write_reg(CSR_WRAP_ROWS, LEN_W'(11'h7FE));
      send_word(1'b1);
      repeat (3) send_word(1'b0);
   endtask

   task automatic test_live_register_change();
      settle();
      write_reg(CSR_ROW_LENGTH, LEN_W'(6));
      write_reg(CSR_STRIP_COUNT, LEN_W'(3));
      write_reg(CSR_WRAP_ROWS, LEN_W'(0));
      send_word(1'b1);
      repeat (8) send_word(1'b0);
      // Shrink the row under the walker: the column is already past the end.
      settle();
      write_reg(CSR_ROW_LENGTH, LEN_W'(3));
      repeat (6) send_word(1'b0);
      // Drop to one strip: the strip in progress becomes the last.
      settle();
      write_reg(CSR_STRIP_COUNT, LEN_W'(1));
      repeat (10) send_word(1'b0);
   endtask

   task automatic test_index_saturation();
      settle();
      write_reg(CSR_ROW_LENGTH, LEN_W'(2));
      write_reg(CSR_STRIP_COUNT, CNT_MAX);
      write_reg(CSR_WRAP_ROWS, LEN_W'(0));
      send_word(1'b1);
      while (!(strip_no == SATURATING_STRIP - 1 && walk_phase == PH_STITCH2))
         send_word(1'b0);
      // Widen the rows just before the next strip loads its bases.
      settle();
      write_reg(CSR_ROW_LENGTH, LEN_MAX);
      repeat (6) send_word(1'b0);
      settle();
      write_reg(CSR_ROW_LENGTH, LEN_W'(2));
      repeat (8) send_word(1'b0);
   endtask

   task automatic test_backpressure();
      settle();
      write_reg(CSR_ROW_LENGTH, LEN_W'(4));
      write_reg(CSR_STRIP_COUNT, LEN_W'(3));
      hold_off_left = HOLD_OFF_CYCLES;
      send_word(1'b1);
      repeat (59) send_word(1'b0);
   endtask

   task automatic randomise_registers();
      logic [LEN_W-1:0] value;
      if ($urandom_range(9) < 7) begin
         case ($urandom_range(9))
            0: value = boundary_value($urandom_range(5));
            1: value = LEN_W'($urandom_range(2047));
            default: value = LEN_W'($urandom_range(2, 8));
         endcase
         write_reg(CSR_ROW_LENGTH, value);
      end
      if ($urandom_range(9) < 7) begin
         case ($urandom_range(9))
            0: value = boundary_value($urandom_range(5));
            1: value = LEN_W'($urandom_range(2047));
            default: value = LEN_W'($urandom_range(1, 6));
         endcase
         write_reg(CSR_STRIP_COUNT, value);
      end
      if ($urandom_range(9) < 5) write_reg(CSR_WRAP_ROWS, LEN_W'($urandom_range(2047)));
   endtask

   task automatic test_random_traffic();
      for (int phase_no = 0; phase_no < 4; phase_no++) begin
         case (phase_no)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 53; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 53; end
            default: begin send_gap_pct = 28; recv_stall_pct = 28; end
         endcase
         for (int burst = 0; burst < 6; burst++) begin
            settle();
            randomise_registers();
            // Mostly whole meshes; an occasional restart cuts one short.
            for (int n = 0; n < 28; n++)
               send_word(mesh_active ? ($urandom_range(99) < 3) : ($urandom_range(99) < 85));
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.restart = 1'b0;
      csr_chan.valid   = 1'b0;
      csr_chan.index   = CSR_ROW_LENGTH;
      csr_chan.data    = '0;
      rsp_chan.ready   = 1'b0;
      mesh_cfg         = '{row_length: LEN_MIN, strip_count: CNT_MIN, wrap_rows: 1'b0};
      strip_no         = '0;
      col_no           = '0;
      on_upper         = 1'b0;
      walk_phase       = PH_BODY;
      mesh_active      = 1'b0;
      lower_base       = 0;
      upper_base       = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_wrapped_ring();
      test_restart_mid_mesh();
      test_single_strip_wrap();
      test_register_saturation();
      test_live_register_change();
      test_index_saturation();
      test_backpressure();
      test_random_traffic();

      settle();
      if (failures == 0 && pending_indices.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: files.f
rtl/gsig_pkg.sv
rtl/gsig_ifs.sv
rtl/gsig_core.sv
rtl/grid_strip_index_generator.sv
tb/tb_grid_strip_index_generator.sv
